// ----- sv/hcm_pkg.sv -----
// Shared types, constants and a helper function for the count heat-map color block.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package hcm_pkg;

	localparam int COUNT_BITS = 24;
	localparam int FRAC_BITS  = 16;
	localparam int DIV_CELLS  = FRAC_BITS;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [FRAC_BITS+2:0] ONE_S = {2'b00, ONE};
	localparam logic [FRAC_BITS+2:0] TWO_ONE = {1'b0, ONE, 1'b0};

	// Rounded constants of the hue rule, as FRAC_BITS fractions.
	localparam logic [FRAC_BITS-1:0] H65 =
		FRAC_BITS'((65 * (1 << FRAC_BITS) + 50) / 100);
	localparam logic [FRAC_BITS-1:0] THIRD =
		FRAC_BITS'((2 * (1 << FRAC_BITS) + 3) / 6);
	localparam logic [FRAC_BITS-1:0] TWO3 =
		FRAC_BITS'((4 * (1 << FRAC_BITS) + 3) / 6);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MIN = 2'd0,
		CFG_MAX = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_MUL  = 2'd0,
		MODE_PASS = 2'd1,
		MODE_ZERO = 2'd2
	} chan_mode_t;

	// One item on its way through the divider chain.
	typedef struct packed {
		logic                   forced;
		logic                   force_one;
		logic [COUNT_BITS-1:0]  rem;
		logic [COUNT_BITS-1:0]  span;
		logic [FRAC_BITS-1:0]   quo;
	} div_item_t;

	typedef struct packed {
		chan_mode_t             mode;
		logic [FRAC_BITS+3:0]   fac;
	} chan_prep_t;

	// Wraps a hue into [0, ONE] and picks the piece of the hue rule.
	function automatic chan_prep_t chan_prep(input logic signed [FRAC_BITS+2:0] g_raw);
		logic signed [FRAC_BITS+2:0] g_w;
		logic signed [FRAC_BITS+2:0] d_s;
		logic [FRAC_BITS:0]   g;
		logic [FRAC_BITS:0]   d;
		logic [FRAC_BITS+3:0] g6;
		logic [FRAC_BITS+1:0] g2;
		logic [FRAC_BITS+2:0] g3;
		chan_prep_t r;
		g_w = g_raw;
		if (g_w < 0)
			g_w = g_w + ONE_S;
		if (g_w > ONE_S)
			g_w = g_w - ONE_S;
		g  = g_w[FRAC_BITS:0];
		g6 = (FRAC_BITS+4)'(g) * (FRAC_BITS+4)'(6);
		g2 = {1'b0, g} << 1;
		g3 = (FRAC_BITS+3)'(g) * (FRAC_BITS+3)'(3);
		d_s = $signed({3'b000, TWO3}) - g_w;
		if (d_s < 0)
			d = '0;
		else
			d = d_s[FRAC_BITS:0];
		if (g6 < (FRAC_BITS+4)'(ONE)) begin
			r.mode = MODE_MUL;
			r.fac  = g6;
		end else if (g2 < (FRAC_BITS+2)'(ONE)) begin
			r.mode = MODE_PASS;
			r.fac  = '0;
		end else if (g3 < TWO_ONE) begin
			r.mode = MODE_MUL;
			r.fac  = (FRAC_BITS+4)'(d) * (FRAC_BITS+4)'(6);
		end else begin
			r.mode = MODE_ZERO;
			r.fac  = '0;
		end
		return r;
	endfunction

endpackage

// ----- sv/count_heat_map_color_top.sv -----
// Top level of the count heat-map color block: configuration registers and the cell chain.
// Instantiates hcm_front, hcm_div_cell and hcm_color; uses hcm_pkg.
`timescale 1ns / 1ps
//
// Maps one 24-bit per-pixel count to an 8-bit RGB heat-map color.
// Input items arrive on s_tvalid/s_tready/s_tdata (the count); results leave on
// m_tvalid/m_tready/m_tdata as red, green and blue bytes. The range bounds
// min_count and max_count are written through cfg_valid/cfg_index/cfg_data,
// which is always ready; write them only while no item is in flight.
// An item passes a front cell that orders the count against the range, a chain
// of 16 divider cells that each produce one bit of t, and four color stages.
// That is 21 registers; the first loads at the accepting edge, the last drives m_tvalid.
// One item is accepted per cycle while m_tready does not stall the chain; the cell chain
// sets that figure, since every cell holds one item and hands it on each unstalled cycle.
// Each stage moves only when the stage after it is empty or moving, so a stall
// on m_tready fills the chain from the output back and then lowers s_tready;
// empty stages keep filling meanwhile. Reset clears both bounds to zero and
// empties the chain.
//

module count_heat_map_color_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [hcm_pkg::COUNT_BITS-1:0]       s_tdata,   // [23:0] count
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [23:0]                          m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hcm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [hcm_pkg::COUNT_BITS-1:0]       cfg_data
);

	localparam int N = hcm_pkg::DIV_CELLS;

	logic [hcm_pkg::COUNT_BITS-1:0] min_count_q;
	logic [hcm_pkg::COUNT_BITS-1:0] max_count_q;

	logic               chain_valid [N+1];
	logic               chain_ready [N+1];
	hcm_pkg::div_item_t chain_data  [N+1];

	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_count_q <= '0;
			max_count_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				hcm_pkg::CFG_MIN: min_count_q <= cfg_data;
				hcm_pkg::CFG_MAX: max_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.count     (s_tdata),
		.lo        (min_count_q),
		.hi        (max_count_q),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_data  (chain_data[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		hcm_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	hcm_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[N]),
		.in_ready  (chain_ready[N]),
		.in_data   (chain_data[N]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	assign m_tdata = {blue, green, red};

endmodule

// ----- sv/hcm_front.sv -----
// Front cell of the heat-map color block: orders the count against the range.
// Resolves the saturated and equal-bound cases and sets up the division; uses hcm_pkg.
`timescale 1ns / 1ps

module hcm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [hcm_pkg::COUNT_BITS-1:0]    count,
	input  logic [hcm_pkg::COUNT_BITS-1:0]    lo,
	input  logic [hcm_pkg::COUNT_BITS-1:0]    hi,
	output logic                              out_valid,
	input  logic                              out_ready,
	output hcm_pkg::div_item_t                out_data
);

	logic               valid_q;
	hcm_pkg::div_item_t data_q;
	hcm_pkg::div_item_t nxt;

	always_comb begin
		nxt = '0;
		if (hi == lo) begin
			nxt.forced    = 1'b1;
			nxt.force_one = (hi != '0);
		end else if (hi > lo) begin
			if (count <= lo) begin
				nxt.forced = 1'b1;
			end else if (count >= hi) begin
				nxt.forced    = 1'b1;
				nxt.force_one = 1'b1;
			end else begin
				nxt.rem  = count - lo;
				nxt.span = hi - lo;
			end
		end else begin
			// Reversed bounds map decreasing counts to hotter colors.
			if (count >= lo) begin
				nxt.forced = 1'b1;
			end else if (count <= hi) begin
				nxt.forced    = 1'b1;
				nxt.force_one = 1'b1;
			end else begin
				nxt.rem  = lo - count;
				nxt.span = lo - hi;
			end
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_q <= nxt;
		end
	end

	a_front_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !data_q.forced) |-> (data_q.rem < data_q.span))
		else $error("front cell: difference not below span");

endmodule

// ----- sv/hcm_div_cell.sv -----
// One cell of the divider chain: a restoring step that yields one quotient bit.
// Passes the item to its right neighbor each cycle unless the neighbor stalls; uses hcm_pkg.
`timescale 1ns / 1ps

module hcm_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hcm_pkg::div_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hcm_pkg::div_item_t   out_data
);

	logic                           valid_q;
	hcm_pkg::div_item_t             data_q;
	hcm_pkg::div_item_t             nxt;
	logic [hcm_pkg::COUNT_BITS:0]   rem2;
	logic [hcm_pkg::COUNT_BITS:0]   diff;
	logic                           take;

	always_comb begin
		rem2 = {in_data.rem, 1'b0};
		diff = rem2 - {1'b0, in_data.span};
		take = (rem2 >= {1'b0, in_data.span});
		nxt  = in_data;
		nxt.rem = take ? diff[hcm_pkg::COUNT_BITS-1:0] : rem2[hcm_pkg::COUNT_BITS-1:0];
		nxt.quo = {in_data.quo[hcm_pkg::FRAC_BITS-2:0], take};
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_q <= nxt;
		end
	end

	a_cell_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !data_q.forced) |-> (data_q.rem < data_q.span))
		else $error("divider cell: partial remainder not below span");

endmodule

// ----- sv/hcm_color.sv -----
// Color stages of the heat-map block: hue from t, hue rule per channel, scale to bytes.
// Four registered stages after the divider chain; uses hcm_pkg.
`timescale 1ns / 1ps

module hcm_color (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hcm_pkg::div_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue
);

	localparam int F = hcm_pkg::FRAC_BITS;

	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [F:0]      t_in;
	logic [F:0]      one_minus_t;
	logic [2*F:0]    h_prod;
	logic [F:0]      t_s1;
	logic [F-1:0]    h_s1;

	logic signed [F+2:0]   g_raw [3];
	hcm_pkg::chan_prep_t   prep  [3];
	logic [F:0]            t_s2;
	hcm_pkg::chan_prep_t   prep_s2 [3];

	logic [2*F+4:0]  prod  [3];
	logic [F:0]      x_nxt [3];
	logic [F:0]      x_s3  [3];

	logic [F+8:0]    scaled [3];
	logic [7:0]      byte_s4 [3];

	assign rdy4     = !v4_q || out_ready;
	assign rdy3     = !v3_q || rdy4;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign in_ready = rdy1;

	// Stage 1: pick t and form the hue 0.65 * (1 - t).
	always_comb begin
		if (in_data.forced)
			t_in = in_data.force_one ? hcm_pkg::ONE : '0;
		else
			t_in = {1'b0, in_data.quo};
		one_minus_t = hcm_pkg::ONE - t_in;
		h_prod = (2*F+1)'(hcm_pkg::H65) * (2*F+1)'(one_minus_t);
	end

	// Stage 2: red, green and blue hues, wrapped, and the piece of the rule.
	always_comb begin
		g_raw[0] = $signed({3'b000, h_s1}) + $signed({3'b000, hcm_pkg::THIRD});
		g_raw[1] = $signed({3'b000, h_s1});
		g_raw[2] = $signed({3'b000, h_s1}) - $signed({3'b000, hcm_pkg::THIRD});
		for (int i = 0; i < 3; i++) begin
			prep[i] = hcm_pkg::chan_prep(g_raw[i]);
		end
	end

	// Stage 3: channel fraction, limited to one.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = (2*F+5)'(t_s2) * (2*F+5)'(prep_s2[i].fac);
			case (prep_s2[i].mode)
				hcm_pkg::MODE_MUL: begin
					if (prod[i][2*F+4:F] > (F+5)'(hcm_pkg::ONE))
						x_nxt[i] = hcm_pkg::ONE;
					else
						x_nxt[i] = prod[i][2*F:F];
				end
				hcm_pkg::MODE_PASS: x_nxt[i] = t_s2;
				default:            x_nxt[i] = '0;
			endcase
		end
	end

	// Stage 4: floor(x * 255) as a shift and subtract.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			scaled[i] = {x_s3[i], 8'h00} - (F+9)'(x_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			t_s1 <= t_in;
			h_s1 <= h_prod[2*F-1:F];
		end
		if (rdy2) begin
			t_s2 <= t_s1;
			for (int i = 0; i < 3; i++) prep_s2[i] <= prep[i];
		end
		if (rdy3) begin
			for (int i = 0; i < 3; i++) x_s3[i] <= x_nxt[i];
		end
		if (rdy4) begin
			for (int i = 0; i < 3; i++) byte_s4[i] <= scaled[i][F+7:F];
		end
	end

	assign out_valid = v4_q;
	assign red       = byte_s4[0];
	assign green     = byte_s4[1];
	assign blue      = byte_s4[2];

	a_t_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> (t_s1 <= hcm_pkg::ONE))
		else $error("color: t above one");

	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v3_q |-> ((x_s3[0] <= hcm_pkg::ONE) && (x_s3[1] <= hcm_pkg::ONE)
			&& (x_s3[2] <= hcm_pkg::ONE)))
		else $error("color: channel fraction above one");

endmodule
